// ----- src/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared types and constants for the priority queue front and back parts.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int QDEPTH = 2;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_POP    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_COUNT  = 3'd3,
      OP_REMOVE = 3'd4,
      OP_EXISTS = 3'd5
   } op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] item_value;
      logic [7:0]         item_priority;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic [7:0]         out_priority;
      logic               found;
      logic [4:0]         match_count;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
      logic [7:0]         pri;
   } cmd_type;

   typedef struct packed {
      logic [7:0]         pri;
      logic signed [31:0] value;
   } entry_type;

endpackage

// ----- src/spq_front.sv -----
// ----------------------------------------------------------------------------
// Priority queue front end
// Accepts request beats, drops unknown operations and queues the rest.
// ----------------------------------------------------------------------------
module spq_front (
   input  logic             clock,
   input  logic             reset,
   input  spq_pkg::req_type req_data,
   input  logic             req_valid,
   output logic             req_stall,
   output spq_pkg::cmd_type cmd_data,
   output logic             cmd_valid,
   input  logic             cmd_take
);
   import spq_pkg::*;

   localparam int QP_W = $clog2(QDEPTH);
   localparam int QF_W = $clog2(QDEPTH + 1);

   cmd_type           q_ff [QDEPTH];
   logic [QP_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QF_W-1:0]   fill_ff, fill_in;
   logic              known, push, pull;
   cmd_type           cmd_new;

   assign known     = req_data.operation <= 3'(OP_EXISTS);
   assign req_stall = fill_ff == QF_W'(QDEPTH);
   assign push      = req_valid && !req_stall && known;
   assign pull      = cmd_take && cmd_valid;
   assign cmd_valid = fill_ff != '0;
   assign cmd_data  = q_ff[rd_ff];

   always_comb begin
      cmd_new.op    = op_type'(req_data.operation);
      cmd_new.value = req_data.item_value;
      cmd_new.pri   = req_data.item_priority;
      wr_in   = push ? wr_ff + QP_W'(1) : wr_ff;
      rd_in   = pull ? rd_ff + QP_W'(1) : rd_ff;
      fill_in = fill_ff + QF_W'(push) - QF_W'(pull);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cmd_new;
      end
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ----- src/spq_back.sv -----
// ----------------------------------------------------------------------------
// Priority queue back end
// Holds the sorted store and carries out one queued operation at a time.
// ----------------------------------------------------------------------------
module spq_back (
   input  logic             clock,
   input  logic             reset,
   input  spq_pkg::cmd_type cmd_data,
   input  logic             cmd_valid,
   output logic             cmd_take,
   output spq_pkg::rsp_type rsp_data,
   output logic             rsp_valid,
   input  logic             rsp_stall
);
   import spq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EVAL, S_INS, S_EMIT
   } state_type;

   entry_type         mem [DEPTH];
   entry_type         rd_data_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   entry_type         mem_wd;

   state_type         state_ff, state_in, ret_ff, ret_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]  occ_ff, occ_in, cnt_ff, cnt_in, k_ff, k_in;
   logic [IDX_W-1:0]  idx_ff, idx_in, pos_ff, pos_in;
   logic              hit_ff, hit_in, phase_ff, phase_in;
   rsp_type           res_ff, res_in, out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   entry_type         d;
   logic              scan_end, out_free, pri_eq, pri_any;
   logic [CNT_W-1:0]  next_idx, cnt_nx, k_nx;
   logic              hit_nx;

   assign rsp_data  = out_ff;
   assign rsp_valid = out_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      d        = rd_data_ff;
      next_idx = CNT_W'(idx_ff) + CNT_W'(1);
      scan_end = next_idx == occ_ff;
      pri_eq   = d.pri == cmd_ff.pri;
      pri_any  = pri_eq || (cmd_ff.pri == 8'd0);
      cnt_nx   = cnt_ff + CNT_W'(pri_eq);
      k_nx     = k_ff + CNT_W'(1);
      hit_nx   = hit_ff || ((d.value == cmd_ff.value) && pri_any);

      state_in     = state_ff;
      ret_in       = ret_ff;
      cmd_in       = cmd_ff;
      occ_in       = occ_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      phase_in     = phase_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      cmd_take     = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_wd       = d;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take   = 1'b1;
               cmd_in     = cmd_data;
               phase_in   = 1'b0;
               hit_in     = 1'b0;
               cnt_in     = '0;
               k_in       = '0;
               idx_in     = '0;
               pos_in     = '0;
               res_in     = '0;
               res_in.last = 1'b1;
               ret_in     = S_IDLE;
               case (cmd_data.op)
                  OP_ADD: begin
                     if (occ_ff == CNT_W'(DEPTH)) begin
                        res_in.status = ST_FULL;
                        state_in      = S_EMIT;
                     end else if (occ_ff == '0) begin
                        state_in = S_INS;
                     end else begin
                        idx_in   = IDX_W'(occ_ff - CNT_W'(1));
                        state_in = S_READ;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (occ_ff == '0) begin
                        res_in.status = ST_EMPTY;
                        state_in      = S_EMIT;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = (occ_ff == '0) ? S_EMIT : S_READ;
                  end
               endcase
            end
         end

         S_READ: begin
            state_in = S_EVAL;
         end

         S_EVAL: begin
            case (cmd_ff.op)
               OP_ADD: begin
                  // Walk down from the tail, moving lower priorities up one place.
                  if (d.pri >= cmd_ff.pri) begin
                     pos_in   = idx_ff + IDX_W'(1);
                     state_in = S_INS;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = idx_ff + IDX_W'(1);
                     if (idx_ff == '0) begin
                        pos_in   = '0;
                        state_in = S_INS;
                     end else begin
                        idx_in   = idx_ff - IDX_W'(1);
                        state_in = S_READ;
                     end
                  end
               end
               OP_POP, OP_PEEK: begin
                  if (!phase_ff) begin
                     res_in.out_value    = d.value;
                     res_in.out_priority = d.pri;
                     res_in.found        = 1'b1;
                     state_in            = S_EMIT;
                     if (cmd_ff.op == OP_PEEK) begin
                        ret_in = S_IDLE;
                     end else if (occ_ff == CNT_W'(1)) begin
                        occ_in = '0;
                        ret_in = S_IDLE;
                     end else begin
                        phase_in = 1'b1;
                        idx_in   = IDX_W'(1);
                        ret_in   = S_READ;
                     end
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = idx_ff - IDX_W'(1);
                     if (scan_end) begin
                        occ_in   = occ_ff - CNT_W'(1);
                        state_in = S_IDLE;
                     end else begin
                        idx_in   = idx_ff + IDX_W'(1);
                        state_in = S_READ;
                     end
                  end
               end
               OP_COUNT: begin
                  cnt_in = cnt_ff + CNT_W'(pri_any);
                  if (scan_end) begin
                     res_in.found       = cnt_in != '0;
                     res_in.match_count = 5'(cnt_in);
                     state_in           = S_EMIT;
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = S_READ;
                  end
               end
               OP_EXISTS: begin
                  hit_in = hit_nx;
                  if (scan_end) begin
                     res_in.found = hit_nx;
                     state_in     = S_EMIT;
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = S_READ;
                  end
               end
               OP_REMOVE: begin
                  if (!phase_ff) begin
                     // First pass counts, so that each beat carries the total.
                     cnt_in = cnt_nx;
                     if (!scan_end) begin
                        idx_in   = idx_ff + IDX_W'(1);
                        state_in = S_READ;
                     end else if (cnt_nx == '0) begin
                        state_in = S_EMIT;
                     end else begin
                        phase_in = 1'b1;
                        idx_in   = '0;
                        pos_in   = '0;
                        state_in = S_READ;
                     end
                  end else begin
                     // Second pass emits matches and packs the survivors down.
                     if (!scan_end) begin
                        idx_in = idx_ff + IDX_W'(1);
                     end
                     if (pri_eq) begin
                        k_in                = k_nx;
                        res_in.out_value    = d.value;
                        res_in.out_priority = cmd_ff.pri;
                        res_in.found        = 1'b1;
                        res_in.match_count  = 5'(cnt_ff);
                        res_in.status       = ST_OK;
                        res_in.last         = k_nx == cnt_ff;
                        state_in            = S_EMIT;
                        ret_in              = scan_end ? S_IDLE : S_READ;
                        if (scan_end) begin
                           occ_in = CNT_W'(pos_ff);
                        end
                     end else begin
                        mem_we = 1'b1;
                        mem_wa = pos_ff;
                        pos_in = pos_ff + IDX_W'(1);
                        if (scan_end) begin
                           occ_in   = CNT_W'(pos_ff) + CNT_W'(1);
                           state_in = S_IDLE;
                        end else begin
                           state_in = S_READ;
                        end
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_INS: begin
            mem_we       = 1'b1;
            mem_wa       = pos_ff;
            mem_wd.pri   = cmd_ff.pri;
            mem_wd.value = cmd_ff.value;
            occ_in       = occ_ff + CNT_W'(1);
            state_in     = S_EMIT;
            ret_in       = S_IDLE;
         end

         S_EMIT: begin
            if (out_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = ret_ff;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      cmd_ff   <= cmd_in;
      cnt_ff   <= cnt_in;
      k_ff     <= k_in;
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      hit_ff   <= hit_in;
      phase_ff <= phase_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ----- src/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded store of value and priority pairs, highest priority first and
// first-in first-out among equal priorities.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel as one beat per operation: add, pop,
// peek, count, remove by priority or exists. Results leave on the rsp_
// channel; every operation gives one beat, except remove, which gives one
// beat per removed entry (one if none match); the final beat sets last.
// Operation codes six and seven are taken and discarded without a result.
// A two-entry command queue sits between the request side and the engine,
// so requests are taken while the engine is busy until that queue fills.
// The engine reads the store through one registered read port, visiting
// each entry in a read state and then an evaluate state. Peek visits only
// the head entry. An empty store or a full add answers without visiting
// the store, and an add to an empty store goes straight to insertion.
// Reset empties the store; stored contents are not cleared. While rsp_stall
// is high the result beat holds and the engine waits before its next beat.
// ----------------------------------------------------------------------------
module stable_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   cmd_type cmd_data;
   logic    cmd_valid;
   logic    cmd_take;

   spq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd_data  (cmd_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take)
   );

   spq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

   a_reset_idle : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   a_full_beat : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |-> (!rsp_data.found && rsp_data.last))
      else $error("dropped add reported a hit or was not final");

   a_empty_beat : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_EMPTY) |-> (!rsp_data.found && rsp_data.last))
      else $error("empty queue beat reported a hit or was not final");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.match_count) <= 32'(DEPTH)))
      else $error("match count beyond store depth");

endmodule
